// ----- rtl/core/pgen_pkg.sv -----
// Shared constants, field widths and the sine table of the plasma pixel generator.
`timescale 1ns / 1ps
`default_nettype none

package pgen_pkg;

  localparam int X_W = 9;
  localparam int Y_W = 8;
  localparam int P_W = 8;
  localparam int C_W = 8;
  localparam int IDX_W = 8;

  localparam int SCREEN_WIDTH_DEF = 320;
  localparam int SCREEN_HEIGHT_DEF = 200;
  localparam int BLOCK_SIZE_DEF = 4;

  localparam int STAGES = 5;

  // Wave formula coefficients.
  localparam logic [IDX_W-1:0] K_H_BX = 8'd3;
  localparam logic [IDX_W-1:0] K_H_PH = 8'd2;
  localparam logic [IDX_W-1:0] K_V_BY = 8'd3;
  localparam logic [IDX_W-1:0] K_V_PH = 8'd3;
  localparam logic [IDX_W-1:0] K_SX_PH = 8'd3;
  localparam logic [IDX_W-1:0] K_SY_PH = 8'd5;
  localparam logic [IDX_W-1:0] K_SY_OFF = 8'd64;
  localparam int WAVE_COUNT = 3;
  localparam int SUM_W = 10;
  localparam logic [C_W-1:0] COLOR_MAX = 8'd254;

  localparam logic [C_W-1:0] SINE_ROM [256] = '{
    8'd127, 8'd130, 8'd133, 8'd136, 8'd140, 8'd143, 8'd146, 8'd149,
    8'd152, 8'd155, 8'd158, 8'd161, 8'd164, 8'd167, 8'd170, 8'd173,
    8'd176, 8'd179, 8'd182, 8'd185, 8'd187, 8'd190, 8'd193, 8'd195,
    8'd198, 8'd201, 8'd203, 8'd206, 8'd208, 8'd211, 8'd213, 8'd215,
    8'd217, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232,
    8'd233, 8'd235, 8'd237, 8'd238, 8'd240, 8'd241, 8'd242, 8'd243,
    8'd245, 8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd252,
    8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
    8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd253, 8'd253, 8'd252,
    8'd252, 8'd251, 8'd250, 8'd250, 8'd249, 8'd248, 8'd247, 8'd246,
    8'd244, 8'd243, 8'd242, 8'd240, 8'd239, 8'd237, 8'd236, 8'd234,
    8'd232, 8'd231, 8'd229, 8'd227, 8'd225, 8'd223, 8'd221, 8'd219,
    8'd216, 8'd214, 8'd212, 8'd209, 8'd207, 8'd204, 8'd202, 8'd199,
    8'd197, 8'd194, 8'd191, 8'd189, 8'd186, 8'd183, 8'd180, 8'd177,
    8'd175, 8'd172, 8'd169, 8'd166, 8'd163, 8'd160, 8'd157, 8'd154,
    8'd150, 8'd147, 8'd144, 8'd141, 8'd138, 8'd135, 8'd131, 8'd129,
    8'd125, 8'd123, 8'd119, 8'd116, 8'd113, 8'd110, 8'd107, 8'd104,
    8'd100, 8'd97,  8'd94,  8'd91,  8'd88,  8'd85,  8'd82,  8'd79,
    8'd77,  8'd74,  8'd71,  8'd68,  8'd65,  8'd63,  8'd60,  8'd57,
    8'd55,  8'd52,  8'd50,  8'd47,  8'd45,  8'd42,  8'd40,  8'd38,
    8'd35,  8'd33,  8'd31,  8'd29,  8'd27,  8'd25,  8'd23,  8'd22,
    8'd20,  8'd18,  8'd17,  8'd15,  8'd14,  8'd12,  8'd11,  8'd10,
    8'd8,   8'd7,   8'd6,   8'd5,   8'd4,   8'd4,   8'd3,   8'd2,
    8'd2,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd2,
    8'd2,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,
    8'd11,  8'd12,  8'd13,  8'd14,  8'd16,  8'd17,  8'd19,  8'd21,
    8'd22,  8'd24,  8'd26,  8'd28,  8'd30,  8'd32,  8'd34,  8'd37,
    8'd39,  8'd41,  8'd43,  8'd46,  8'd48,  8'd51,  8'd53,  8'd56,
    8'd59,  8'd61,  8'd64,  8'd67,  8'd69,  8'd72,  8'd75,  8'd78,
    8'd81,  8'd84,  8'd87,  8'd90,  8'd93,  8'd96,  8'd99,  8'd102,
    8'd105, 8'd108, 8'd111, 8'd114, 8'd118, 8'd121, 8'd124, 8'd127
  };

endpackage

`default_nettype wire

// ----- rtl/core/pgen_in_if.sv -----
// Pixel request channel carrying the screen position and frame phase.
`timescale 1ns / 1ps
`default_nettype none

interface pgen_in_if;
  logic                      valid;
  logic                      ready;
  logic [pgen_pkg::X_W-1:0] screen_x;
  logic [pgen_pkg::Y_W-1:0] screen_y;
  logic [pgen_pkg::P_W-1:0] frame_phase;

  modport source (output valid, output screen_x, output screen_y, output frame_phase,
                  input ready);
  modport sink (input valid, input screen_x, input screen_y, input frame_phase,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pgen_out_if.sv -----
// Result channel carrying the palette index of one pixel.
`timescale 1ns / 1ps
`default_nettype none

interface pgen_out_if;
  logic                      valid;
  logic                      ready;
  logic [pgen_pkg::C_W-1:0] color_index;

  modport source (output valid, output color_index, input ready);
  modport sink (input valid, input color_index, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pgen_cdiv.sv -----
// Registered division by a constant through an exact reciprocal multiplication.
`timescale 1ns / 1ps
`default_nettype none

module pgen_cdiv #(
  parameter int N_W = 9,
  parameter int Q_W = 9,
  parameter int DIVISOR = 3
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [N_W-1:0] n,
  output logic      [Q_W-1:0] q
);

  // With the shift set to N_W plus the base-two logarithm of the divisor, rounded
  // up, the rounded-up reciprocal gives the truncated quotient exactly for every
  // numerator.
  localparam int    L_W = $clog2(DIVISOR);
  localparam int    SHIFT = N_W + L_W;
  localparam int    M_W = N_W + 2;
  localparam int    P_W = N_W + M_W;
  localparam longint MUL = ((64'sd1 <<< SHIFT) + DIVISOR - 1) / DIVISOR;

  logic [P_W-1:0] prod;
  logic [Q_W-1:0] q_r;
  logic [Q_W-1:0] q_nxt;

  assign prod  = P_W'(n) * P_W'(M_W'(MUL));
  assign q_nxt = prod[SHIFT +: Q_W];

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

// ----- rtl/core/plasma_pixel_generator.sv -----
// Top level of the plasma pixel generator: five-stage pixel pipeline.
// The block takes one pixel request a cycle while the output does not stall and returns
// its palette index from the last stage; with the result side always ready it delivers
// one word every cycle. Each stage holds at most one word and moves on whenever the
// stage after it is empty or moving, so bubbles close up and a stall at the output backs
// up one stage at a time. The stage count is set by the sine table lookups and the three
// constant-reciprocal multiplications: block position, the two slope quotients of the
// diagonal wave, and the average of three waves, each of which takes a stage of its own.
// The sine table is constant logic and needs no preparation after reset.
`timescale 1ns / 1ps
`default_nettype none

module plasma_pixel_generator #(
  parameter int SCREEN_WIDTH = pgen_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = pgen_pkg::SCREEN_HEIGHT_DEF,
  parameter int BLOCK_SIZE = pgen_pkg::BLOCK_SIZE_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pgen_in_if.sink   in_ch,
  pgen_out_if.source out_ch
);

  localparam int NS = pgen_pkg::STAGES;
  localparam int IW = pgen_pkg::IDX_W;
  localparam int CW = pgen_pkg::C_W;
  localparam int FIELD_W = SCREEN_WIDTH / BLOCK_SIZE;
  localparam int FIELD_H = SCREEN_HEIGHT / BLOCK_SIZE;
  localparam int BX_MAX = ((1 << pgen_pkg::X_W) - 1) / BLOCK_SIZE;
  localparam int BY_MAX = ((1 << pgen_pkg::Y_W) - 1) / BLOCK_SIZE;
  localparam int BX_W = $clog2(BX_MAX + 1);
  localparam int BY_W = $clog2(BY_MAX + 1);
  localparam int PX_W = BX_W + CW;
  localparam int PY_W = BY_W + CW;
  localparam int QX_W = $clog2(BX_MAX * 254 / FIELD_W + 1);
  localparam int QY_W = $clog2(BY_MAX * 254 / FIELD_H + 1);
  localparam int SW = pgen_pkg::SUM_W;

  logic [NS:1] valid_r;
  logic [NS:1] valid_nxt;
  logic [NS:1] en;

  always_comb begin
    en[NS] = !valid_r[NS] || out_ch.ready;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
    valid_nxt[1] = en[1] ? in_ch.valid : valid_r[1];
    for (int k = 2; k <= NS; k++) begin
      valid_nxt[k] = en[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ch.ready = en[1];

  // Stage 1: block position and the two slopes of the diagonal wave.
  logic [BX_W-1:0] bx1;
  logic [BY_W-1:0] by1;
  logic [IW-1:0]   phase1_r;
  logic [CW-1:0]   sx1_r;
  logic [CW-1:0]   sy1_r;
  logic [IW-1:0]   sx_idx;
  logic [IW-1:0]   sy_idx;

  pgen_cdiv #(.N_W(pgen_pkg::X_W), .Q_W(BX_W), .DIVISOR(BLOCK_SIZE)) u_div_bx (
    .clk(clk), .en(en[1]), .n(in_ch.screen_x), .q(bx1)
  );

  pgen_cdiv #(.N_W(pgen_pkg::Y_W), .Q_W(BY_W), .DIVISOR(BLOCK_SIZE)) u_div_by (
    .clk(clk), .en(en[1]), .n(in_ch.screen_y), .q(by1)
  );

  assign sx_idx = in_ch.frame_phase * pgen_pkg::K_SX_PH;
  assign sy_idx = pgen_pkg::K_SY_OFF + in_ch.frame_phase * pgen_pkg::K_SY_PH;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      phase1_r <= in_ch.frame_phase;
      sx1_r    <= pgen_pkg::SINE_ROM[sx_idx];
      sy1_r    <= pgen_pkg::SINE_ROM[sy_idx];
    end
  end

  // Stage 2: slope products and the horizontal and vertical waves.
  logic [PX_W-1:0] px2_r;
  logic [PY_W-1:0] py2_r;
  logic [CW-1:0]   h2_r;
  logic [CW-1:0]   v2_r;
  logic [IW-1:0]   phase2_r;
  logic [IW-1:0]   h_idx;
  logic [IW-1:0]   v_idx;

  assign h_idx = IW'(bx1) * pgen_pkg::K_H_BX + phase1_r * pgen_pkg::K_H_PH;
  assign v_idx = IW'(by1) * pgen_pkg::K_V_BY + phase1_r * pgen_pkg::K_V_PH;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      px2_r    <= PX_W'(bx1) * PX_W'(sx1_r);
      py2_r    <= PY_W'(by1) * PY_W'(sy1_r);
      h2_r     <= pgen_pkg::SINE_ROM[h_idx];
      v2_r     <= pgen_pkg::SINE_ROM[v_idx];
      phase2_r <= phase1_r;
    end
  end

  // Stage 3: scale the slope products down to the field size.
  logic [QX_W-1:0] qx3;
  logic [QY_W-1:0] qy3;
  logic [CW-1:0]   h3_r;
  logic [CW-1:0]   v3_r;
  logic [IW-1:0]   phase3_r;

  pgen_cdiv #(.N_W(PX_W), .Q_W(QX_W), .DIVISOR(FIELD_W)) u_div_qx (
    .clk(clk), .en(en[3]), .n(px2_r), .q(qx3)
  );

  pgen_cdiv #(.N_W(PY_W), .Q_W(QY_W), .DIVISOR(FIELD_H)) u_div_qy (
    .clk(clk), .en(en[3]), .n(py2_r), .q(qy3)
  );

  always_ff @(posedge clk) begin
    if (en[3]) begin
      h3_r     <= h2_r;
      v3_r     <= v2_r;
      phase3_r <= phase2_r;
    end
  end

  // Stage 4: diagonal wave.
  logic [CW-1:0] d4_r;
  logic [CW-1:0] h4_r;
  logic [CW-1:0] v4_r;
  logic [IW-1:0] d_idx;

  assign d_idx = IW'(qx3) + IW'(qy3) + phase3_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      d4_r <= pgen_pkg::SINE_ROM[d_idx];
      h4_r <= h3_r;
      v4_r <= v3_r;
    end
  end

  // Stage 5: average of the three waves, truncated.
  logic [SW-1:0] wave_sum;

  assign wave_sum = SW'(h4_r) + SW'(v4_r) + SW'(d4_r);

  pgen_cdiv #(.N_W(SW), .Q_W(CW), .DIVISOR(pgen_pkg::WAVE_COUNT)) u_div_avg (
    .clk(clk), .en(en[5]), .n(wave_sum), .q(out_ch.color_index)
  );

  assign out_ch.valid = valid_r[NS];

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (&valid_r))
    else $error("Input blocked while a pipeline stage is empty.");

  a_color_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.color_index <= pgen_pkg::COLOR_MAX))
    else $error("Palette index above the largest average of three waves.");

  a_word_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r[NS-1] && en[NS]) |=> valid_r[NS])
    else $error("A word was lost between the last two stages.");

  a_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r[3] && !en[3]) |=> valid_r[3])
    else $error("A held word vanished from the middle stage.");

endmodule

`default_nettype wire
